// ===== design/jkse_pkg.sv =====
// Package for the JSON key string extractor.
// Holds payload structs, the token passed from front to back, and byte constants.
// No dependencies.
`default_nettype none
package jkse_pkg;

    localparam int KEY_MAX_BYTES = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int KEY_LEN_W     = 5;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ABANDON = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_of_text;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value_byte;
    } out_item_t;

    typedef enum logic [1:0] {
        TOK_CHAR,
        TOK_ESC,
        TOK_DONE,
        TOK_ABANDON
    } tok_class_t;

    typedef struct packed {
        tok_class_t cls;
        logic [7:0] data;
    } token_t;

endpackage
`default_nettype wire

// ===== design/json_key_string_extractor.sv =====
// JSON key string extractor, top level: front end, token queue, back end.
// Tokens pass the token queue register, then the result register. Throughput: one byte
// per cycle while the token queue is not full; the four-entry queue and the result
// register absorb output stalls. Reset (rst_n low) clears key registers, phase, match
// count, queue and result valid flag at once; no clearing pass. Depends on jkse_pkg.
`default_nettype none
module json_key_string_extractor (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [jkse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [jkse_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             push,
    output logic                                  full,
    input  wire jkse_pkg::in_item_t               item,
    output logic                                  empty,
    input  wire logic                             pop,
    output jkse_pkg::out_item_t                   result
);
    import jkse_pkg::*;

    logic   accept;
    logic   tok_valid;
    token_t tok;
    logic   q_not_empty;
    token_t q_head;
    logic   q_take;

    assign accept = push && !full;

    jkse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .tok_valid (tok_valid),
        .tok       (tok)
    );

    jkse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tok_valid),
        .push_tok  (tok),
        .full      (full),
        .pop       (q_take),
        .not_empty (q_not_empty),
        .head_tok  (q_head)
    );

    jkse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_ready (q_not_empty),
        .tok       (q_head),
        .tok_take  (q_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
`default_nettype wire

// ===== design/jkse_front.sv =====
// Front end of the JSON key string extractor: key registers, key match and phase tracking.
// Classifies each accepted byte into at most one token for the back end.
// Depends on jkse_pkg.
`default_nettype none
module jkse_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [jkse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [jkse_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            accept,
    input  wire jkse_pkg::in_item_t               item,
    output logic                                 tok_valid,
    output jkse_pkg::token_t                     tok
);
    import jkse_pkg::*;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_COLON,
        PH_SPACE,
        PH_VALUE,
        PH_ESCAPE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [KEY_LEN_W-1:0]   match_reg, match_next;
    logic [63:0]            key_low_reg;
    logic [63:0]            key_high_reg;
    logic [KEY_LEN_W-1:0]   key_len_reg;

    logic [KEY_LEN_W-1:0]   len_used;
    logic [KEY_LEN_W-1:0]   m_cur;
    logic [KEY_LEN_W-1:0]   m_inc;
    logic [KEY_LEN_W-1:0]   m_sel;
    logic [127:0]           key_all;
    logic [7:0]             needle;
    logic [7:0]             b;
    logic                   is_space;
    logic                   emit;
    token_t                 tok_c;

    assign len_used = (key_len_reg > KEY_LEN_W'(KEY_MAX_BYTES)) ?
                      KEY_LEN_W'(KEY_MAX_BYTES) : key_len_reg;
    assign m_cur    = (match_reg > len_used + KEY_LEN_W'(1)) ? '0 : match_reg;
    assign m_inc    = m_cur + KEY_LEN_W'(1);
    assign m_sel    = m_cur - KEY_LEN_W'(1);
    assign key_all  = {key_high_reg, key_low_reg};
    assign needle   = (m_cur == '0 || m_cur == len_used + KEY_LEN_W'(1)) ?
                      CH_QUOTE : key_all[m_sel[3:0]*8 +: 8];
    assign b        = item.text_byte;
    assign is_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);

    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        emit       = 1'b0;
        tok_c.cls  = TOK_CHAR;
        tok_c.data = b;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (b == needle)
                begin
                    if (m_inc == len_used + KEY_LEN_W'(2))
                    begin
                        phase_next = PH_COLON;
                        match_next = '0;
                    end
                    else
                    begin
                        match_next = m_inc;
                    end
                end
                else
                begin
                    match_next = (b == CH_QUOTE) ? KEY_LEN_W'(1) : '0;
                end
            end
            PH_COLON:
            begin
                if (b == CH_COLON)
                    phase_next = PH_SPACE;
            end
            PH_SPACE:
            begin
                if (!is_space)
                begin
                    phase_next = (b == CH_QUOTE) ? PH_VALUE : PH_SEARCH;
                    match_next = '0;
                end
            end
            PH_VALUE:
            begin
                if (b == CH_BACKSLASH)
                begin
                    phase_next = PH_ESCAPE;
                end
                else if (b == CH_QUOTE)
                begin
                    emit       = 1'b1;
                    tok_c.cls  = TOK_DONE;
                    phase_next = PH_SEARCH;
                    match_next = '0;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                phase_next = PH_VALUE;
                if (b != CH_R)
                begin
                    emit      = 1'b1;
                    tok_c.cls = TOK_ESC;
                end
            end
            default:
            begin
                phase_next = PH_SEARCH;
                match_next = '0;
            end
        endcase

        // end of text: abandon an open value, return to search
        if (item.last_of_text)
        begin
            if (phase_next == PH_VALUE || phase_next == PH_ESCAPE)
            begin
                emit      = 1'b1;
                tok_c.cls = TOK_ABANDON;
            end
            phase_next = PH_SEARCH;
            match_next = '0;
        end
    end

    assign tok_valid = accept && emit;
    assign tok       = tok_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEARCH;
            match_reg    <= '0;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                match_reg <= match_next;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_KEY_LEN:  key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/jkse_queue.sv =====
// Token queue between the front and back ends of the JSON key string extractor.
// Small register FIFO with a show-ahead head entry.
// Depends on jkse_pkg.
`default_nettype none
module jkse_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire jkse_pkg::token_t push_tok,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output jkse_pkg::token_t      head_tok
);
    import jkse_pkg::*;

    token_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_reg, wr_next;
    logic [QUEUE_PTR_W-1:0] rd_reg, rd_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_tok  = slot_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign wr_next   = do_push ? wr_reg + QUEUE_PTR_W'(1) : wr_reg;
    assign rd_next   = do_pop ? rd_reg + QUEUE_PTR_W'(1) : rd_reg;
    assign cnt_next  = cnt_reg + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_tok;
    end

endmodule
`default_nettype wire

// ===== design/jkse_back.sv =====
// Back end of the JSON key string extractor: escape decode and result register.
// Drains tokens from the queue and presents one result at a time.
// Depends on jkse_pkg.
`default_nettype none
module jkse_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tok_ready,
    input  wire jkse_pkg::token_t tok,
    output logic                  tok_take,
    output logic                  empty,
    input  wire logic             pop,
    output jkse_pkg::out_item_t   result
);
    import jkse_pkg::*;

    out_item_t res_reg, res_next;
    logic      valid_reg;

    always_comb
    begin
        res_next.kind       = KIND_CHAR;
        res_next.value_byte = tok.data;
        case (tok.cls)
            TOK_CHAR: ;
            TOK_ESC:
            begin
                if (tok.data == CH_N)
                    res_next.value_byte = CH_LF;
                else if (tok.data == CH_T)
                    res_next.value_byte = CH_TAB;
            end
            TOK_DONE:
            begin
                res_next.kind       = KIND_DONE;
                res_next.value_byte = '0;
            end
            TOK_ABANDON:
            begin
                res_next.kind       = KIND_ABANDON;
                res_next.value_byte = '0;
            end
            default: ;
        endcase
    end

    assign tok_take = tok_ready && (!valid_reg || pop);
    assign empty    = !valid_reg;
    assign result   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (tok_take)
            valid_reg <= 1'b1;
        else if (pop)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tok_take)
            res_reg <= res_next;
    end

endmodule
`default_nettype wire

// ===== design/jkse_checker.sv =====
// Port-level checker for the JSON key string extractor, bound to the top level.
// Depends on jkse_pkg.
`default_nettype none
module jkse_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    input  wire logic                             full,
    input  wire logic                             empty,
    input  wire logic                             pop,
    input  wire jkse_pkg::out_item_t              result
);
    import jkse_pkg::*;

    logic in_acc;

    assign in_acc = push && !full;

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.kind == KIND_CHAR || result.kind == KIND_DONE ||
                    result.kind == KIND_ABANDON))
        else $error("result kind out of range");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_CHAR) |-> (result.value_byte == 8'd0))
        else $error("end marker carries a nonzero byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !in_acc) ##1 (empty && !in_acc) |=> empty)
        else $error("result appeared without an input transaction");

endmodule

bind json_key_string_extractor jkse_checker u_jkse_checker (.*);
`default_nettype wire
